### src/smhl_pkg.sv
// Shared types and constants for the symbol map lookup block.
// No dependencies; smhl_cell and the top level import this package.
`default_nettype none

package smhl_pkg;

  // Fixed widths of the transaction fields.
  localparam int KEY_W     = 32;
  localparam int LEN_W     = 3;
  localparam int OUT_SYM_W = 16;

  // Legal key lengths in bytes.
  localparam logic [LEN_W-1:0] LEN_MIN  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_MAX  = 3'd4;
  localparam logic [LEN_W-1:0] LEN_BYTE = 3'd1;

  // Request codes.
  typedef enum logic {
    REQ_ADD    = 1'b0,
    REQ_LOOKUP = 1'b1
  } smhl_req_t;

  // Control part of a token that travels along the cell chain.
  typedef struct packed {
    logic vld;     // token carries a transaction
    logic add;     // store a multi-byte key in the first free cell
    logic lkp;     // search the cells for a multi-byte key
    logic placed;  // the add has already found its cell
    logic status;  // add refused, store full
  } smhl_ctl_t;

endpackage

`default_nettype wire

### src/symbol_map_hash_lookup.sv
// Top level of the symbol map lookup block: head stage, direct table, cell chain, output register.
// Depends on smhl_pkg, smhl_ram and smhl_cell.
`default_nettype none

// Maps keys of one to four bytes to symbol numbers. Each transaction either
// adds a key with its symbol or looks a key up, and yields exactly one result
// transaction in order. One-byte keys below DIRECT_CHARS live in a direct
// table that reads as zero until written; one-byte keys at or above it are
// ignored on add and answer zero on lookup. Longer keys are kept in a chain of
// ENTRY_CAPACITY cells, filled in arrival order. Every transaction travels down
// the chain one cell per cycle: an add retires any older live copy of its key
// as it passes and lands in the first unwritten cell, and a lookup picks up the
// symbol of the single live copy, so the newest add of a key always wins. A
// miss answers symbol zero. Once ENTRY_CAPACITY multi-byte adds have been
// stored, further multi-byte adds are refused with status 1 and change
// nothing. A transaction whose length is outside one to four answers zero with
// status 0. The block takes one transaction per cycle when the output side
// keeps up; each result passes through the head stage, every cell of the
// chain and the output register. A stalled output stalls the whole chain,
// and input ready drops with it.
module symbol_map_hash_lookup #(
  parameter int ENTRY_CAPACITY = 256,
  parameter int DIRECT_CHARS   = 128,
  parameter int SYMBOL_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [smhl_pkg::KEY_W-1:0]        in_key_bytes,
  input  logic [smhl_pkg::LEN_W-1:0]        in_key_length,
  input  logic [smhl_pkg::OUT_SYM_W-1:0]    in_new_symbol,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [smhl_pkg::OUT_SYM_W-1:0]    out_found_symbol,
  output logic                              out_status
);

  import smhl_pkg::*;

  // Only the low sixteen symbol bits can ever reach the output.
  localparam int SymW  = (SYMBOL_BITS < OUT_SYM_W) ? SYMBOL_BITS : OUT_SYM_W;
  localparam int CntW  = $clog2(ENTRY_CAPACITY + 1);
  localparam int DirAw = $clog2(DIRECT_CHARS);

  // Global advance: every stage moves when the output register can take data.
  logic adv;
  logic accept;

  // Decode of the incoming transaction.
  logic             len_ok;
  logic             is_add;
  logic [KEY_W-1:0] key_m;
  logic             dir_req;
  logic             hsh_req;
  logic             full;
  logic [DirAw-1:0] dir_addr;
  logic             dir_we;
  logic             dir_re;
  logic [SymW-1:0]  dir_rdata;

  // Direct table valid bits and the count of stored multi-byte entries.
  logic [DIRECT_CHARS-1:0] dv_r, dv_nxt;
  logic [CntW-1:0]         cnt_r, cnt_nxt;

  // Head stage.
  smhl_ctl_t        hd_ctl_r, hd_ctl_nxt;
  logic             hd_dir_r;
  logic             hd_dv_r;
  logic [KEY_W-1:0] hd_key_r;
  logic [LEN_W-1:0] hd_len_r;
  logic [SymW-1:0]  hd_sym_r;

  // Token links between cells; link i feeds cell i.
  smhl_ctl_t        ctl_c   [ENTRY_CAPACITY+1];
  logic [KEY_W-1:0] key_c   [ENTRY_CAPACITY+1];
  logic [LEN_W-1:0] len_c   [ENTRY_CAPACITY+1];
  logic [SymW-1:0]  sym_c   [ENTRY_CAPACITY+1];
  logic [SymW-1:0]  found_c [ENTRY_CAPACITY+1];

  // Output register.
  logic            out_vld_r;
  logic [SymW-1:0] out_found_r;
  logic            out_status_r;

  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv && rst_n;
  assign accept   = in_valid && in_ready;

  always_comb begin
    len_ok = in_key_length inside {[LEN_MIN:LEN_MAX]};
    is_add = (in_req_type == REQ_ADD);

    // Bytes past the key length take no part in the key.
    case (in_key_length)
      3'd1:    key_m = {24'h0, in_key_bytes[7:0]};
      3'd2:    key_m = {16'h0, in_key_bytes[15:0]};
      3'd3:    key_m = {8'h0, in_key_bytes[23:0]};
      default: key_m = in_key_bytes;
    endcase

    dir_req  = len_ok && (in_key_length == LEN_BYTE) &&
               ({1'b0, in_key_bytes[7:0]} < 9'(DIRECT_CHARS));
    hsh_req  = len_ok && (in_key_length != LEN_BYTE);
    full     = (cnt_r == CntW'(ENTRY_CAPACITY));
    dir_addr = in_key_bytes[DirAw-1:0];
    dir_we   = accept && dir_req && is_add;
    dir_re   = accept && dir_req && !is_add;

    dv_nxt = dv_r;
    if (dir_we) begin
      dv_nxt[dir_addr] = 1'b1;
    end

    cnt_nxt = cnt_r;
    if (accept && hsh_req && is_add && !full) begin
      cnt_nxt = cnt_r + CntW'(1);
    end

    hd_ctl_nxt.vld    = accept;
    hd_ctl_nxt.add    = accept && hsh_req && is_add && !full;
    hd_ctl_nxt.lkp    = accept && hsh_req && !is_add;
    hd_ctl_nxt.placed = 1'b0;
    hd_ctl_nxt.status = accept && hsh_req && is_add && full;
  end

  smhl_ram #(
    .WIDTH (SymW),
    .DEPTH (DIRECT_CHARS)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_addr),
    .wdata (in_new_symbol[SymW-1:0]),
    .re    (dir_re),
    .raddr (dir_addr),
    .rdata (dir_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r      <= '0;
      cnt_r     <= '0;
      hd_ctl_r  <= '0;
      hd_dir_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      dv_r  <= dv_nxt;
      cnt_r <= cnt_nxt;
      if (adv) begin
        hd_ctl_r  <= hd_ctl_nxt;
        hd_dir_r  <= dir_re;
        out_vld_r <= ctl_c[ENTRY_CAPACITY].vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hd_dv_r      <= dv_r[dir_addr];
      hd_key_r     <= key_m;
      hd_len_r     <= in_key_length;
      hd_sym_r     <= in_new_symbol[SymW-1:0];
      out_found_r  <= found_c[ENTRY_CAPACITY];
      out_status_r <= ctl_c[ENTRY_CAPACITY].status;
    end
  end

  // The direct table answer joins the token as it enters the chain; a slot
  // never written reads as zero.
  assign ctl_c[0]   = hd_ctl_r;
  assign key_c[0]   = hd_key_r;
  assign len_c[0]   = hd_len_r;
  assign sym_c[0]   = hd_sym_r;
  assign found_c[0] = (hd_dir_r && hd_dv_r) ? dir_rdata : '0;

  for (genvar i = 0; i < ENTRY_CAPACITY; i++) begin : g_cell
    smhl_cell #(
      .SYM_W (SymW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .ctl_i   (ctl_c[i]),
      .key_i   (key_c[i]),
      .len_i   (len_c[i]),
      .sym_i   (sym_c[i]),
      .found_i (found_c[i]),
      .ctl_o   (ctl_c[i+1]),
      .key_o   (key_c[i+1]),
      .len_o   (len_c[i+1]),
      .sym_o   (sym_c[i+1]),
      .found_o (found_c[i+1])
    );
  end

  assign out_valid        = out_vld_r;
  assign out_found_symbol = OUT_SYM_W'(out_found_r);
  assign out_status       = out_status_r;

endmodule

`default_nettype wire

### src/smhl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module smhl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/smhl_cell.sv
// One cell of the entry chain: holds one stored key entry and one token stage.
// Depends on smhl_pkg.
`default_nettype none

module smhl_cell #(
  parameter int SYM_W = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  smhl_pkg::smhl_ctl_t            ctl_i,
  input  logic [smhl_pkg::KEY_W-1:0]     key_i,
  input  logic [smhl_pkg::LEN_W-1:0]     len_i,
  input  logic [SYM_W-1:0]               sym_i,
  input  logic [SYM_W-1:0]               found_i,
  output smhl_pkg::smhl_ctl_t            ctl_o,
  output logic [smhl_pkg::KEY_W-1:0]     key_o,
  output logic [smhl_pkg::LEN_W-1:0]     len_o,
  output logic [SYM_W-1:0]               sym_o,
  output logic [SYM_W-1:0]               found_o
);

  import smhl_pkg::*;

  // Stored entry.
  logic             wr_r, wr_nxt;
  logic             live_r, live_nxt;
  logic [KEY_W-1:0] ekey_r;
  logic [LEN_W-1:0] elen_r;
  logic [SYM_W-1:0] esym_r;

  // Token stage.
  smhl_ctl_t        ctl_r, ctl_nxt;
  logic [KEY_W-1:0] key_r;
  logic [LEN_W-1:0] len_r;
  logic [SYM_W-1:0] sym_r;
  logic [SYM_W-1:0] found_r, found_nxt;

  logic match;
  logic take;
  logic kill;
  logic hit;

  always_comb begin
    match = live_r && (ekey_r == key_i) && (elen_r == len_i);
    take  = ctl_i.vld && ctl_i.add && !ctl_i.placed && !wr_r;
    kill  = ctl_i.vld && ctl_i.add && wr_r && match;
    hit   = ctl_i.vld && ctl_i.lkp && match;

    ctl_nxt        = ctl_i;
    ctl_nxt.placed = ctl_i.placed | take;
    found_nxt      = hit ? esym_r : found_i;

    wr_nxt   = wr_r | take;
    live_nxt = live_r;
    if (take) begin
      live_nxt = 1'b1;
    end else if (kill) begin
      // A newer copy of this key is being stored further down the chain.
      live_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= 1'b0;
      live_r <= 1'b0;
      ctl_r  <= '0;
    end else if (adv) begin
      wr_r   <= wr_nxt;
      live_r <= live_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (take) begin
        ekey_r <= key_i;
        elen_r <= len_i;
        esym_r <= sym_i;
      end
      key_r   <= key_i;
      len_r   <= len_i;
      sym_r   <= sym_i;
      found_r <= found_nxt;
    end
  end

  assign ctl_o   = ctl_r;
  assign key_o   = key_r;
  assign len_o   = len_r;
  assign sym_o   = sym_r;
  assign found_o = found_r;

endmodule

`default_nettype wire

### src/smhl_checker.sv
// Port-level checks for the symbol map lookup block, bound to its top level.
// Depends on symbol_map_hash_lookup being compiled first.
`default_nettype none

module smhl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_found_symbol,
  input logic        out_status
);

  // Reset empties the result side.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result stalls the whole chain, so no new transaction enters.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while the result is stalled");

  // A refused add never carries a symbol.
  a_status_no_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_found_symbol == 16'h0)
    else $error("refused add reports a symbol");

  // A result waiting for the consumer holds its payload.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_found_symbol) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind symbol_map_hash_lookup smhl_checker u_smhl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_found_symbol (out_found_symbol),
  .out_status       (out_status)
);

`default_nettype wire

### verif/symbol_map_hash_lookup_tb.sv
// Self-checking testbench for symbol_map_hash_lookup: directed and random add and lookup traffic.
// Depends on smhl_pkg and the block's RTL; predicts every result and checks each one in order.
`default_nettype none

module symbol_map_hash_lookup_tb;
  import smhl_pkg::*;

  // Block configuration used for this run.
  localparam int ENTRY_CAP    = 256;
  localparam int DIRECT_CHARS = 128;
  localparam int SYMBOL_BITS  = 16;

  // Key lengths outside the legal range of one to four bytes.
  localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
  localparam logic [LEN_W-1:0] LEN_OVER  = 3'd5;
  localparam logic [LEN_W-1:0] LEN_TOP   = 3'd7;

  localparam int RANDOM_ITEMS = 1000;
  // Cycles with no transaction on either side before the run is declared hung.
  localparam int STALL_LIMIT  = 4000;
  // Long output hold-off, well past the depth of the cell chain.
  localparam int HOLD_CYCLES  = 700;

  // One request as it travels from the stimulus queue to the block.
  typedef struct {
    smhl_req_t            req;
    logic [KEY_W-1:0]     key;
    logic [LEN_W-1:0]     len;
    logic [OUT_SYM_W-1:0] sym;
  } map_request_t;

  // One result transaction as the block should produce it.
  typedef struct {
    logic [OUT_SYM_W-1:0] found;
    logic                 status;
  } map_result_t;

  // A multi-byte or one-byte key that has been added at least once.
  typedef struct {
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } known_key_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_req_type = 1'b0;
  logic [KEY_W-1:0]     in_key_bytes = '0;
  logic [LEN_W-1:0]     in_key_length = '0;
  logic [OUT_SYM_W-1:0] in_new_symbol = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_SYM_W-1:0] out_found_symbol;
  logic                 out_status;

  symbol_map_hash_lookup #(
    .ENTRY_CAPACITY(ENTRY_CAP),
    .DIRECT_CHARS  (DIRECT_CHARS),
    .SYMBOL_BITS   (SYMBOL_BITS)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_key_bytes    (in_key_bytes),
    .in_key_length   (in_key_length),
    .in_new_symbol   (in_new_symbol),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found_symbol(out_found_symbol),
    .out_status      (out_status)
  );

  // Requests waiting to be driven, and results still owed by the block.
  map_request_t pending_requests[$];
  map_result_t  owed_results[$];
  known_key_t   known_keys[$];
  map_result_t  predicted;

  // Shadow copy of the block's mapping state. The direct table covers one-byte
  // keys; the entry list mirrors the cell chain in insertion order, so a
  // newest-first scan gives the same answer as the single live copy there.
  logic [OUT_SYM_W-1:0] direct_syms[DIRECT_CHARS];
  logic [KEY_W-1:0]     entry_keys[ENTRY_CAP];
  logic [LEN_W-1:0]     entry_lens[ENTRY_CAP];
  logic [OUT_SYM_W-1:0] entry_syms[ENTRY_CAP];
  int                   entry_total = 0;

  int total_items  = 0;
  int n_accepted   = 0;
  int mismatches   = 0;

  // Traffic shaping by progress through the stimulus: in the first third the
  // receiver is the slow side, in the second the sender is, and in the last
  // third neither side idles except for the one long output hold-off.
  function automatic int idle_pct(bit sender_side);
    if (n_accepted * 3 < total_items) return sender_side ? 12 : 79;
    if (n_accepted * 3 < total_items * 2) return sender_side ? 79 : 12;
    return 0;
  endfunction

  // Only the low key_length bytes of a key count; anything above is ignored.
  function automatic logic [KEY_W-1:0] key_mask(logic [LEN_W-1:0] len);
    if (len >= LEN_MAX) return '1;
    return (32'd1 << (8 * len)) - 32'd1;
  endfunction

  // Applies one accepted request to the shadow state and returns the result
  // the block owes for it.
  function automatic map_result_t apply_map_request(smhl_req_t req, logic [KEY_W-1:0] bytes,
                                                    logic [LEN_W-1:0] len,
                                                    logic [OUT_SYM_W-1:0] sym);
    map_result_t      res;
    logic [KEY_W-1:0] key;
    res = '{found: '0, status: 1'b0};
    key = bytes & key_mask(len);
    if (len < LEN_MIN || len > LEN_MAX) return res;
    if (len == LEN_BYTE) begin
      // One-byte keys at or above the table size are silently dropped.
      if (key < DIRECT_CHARS) begin
        if (req == REQ_ADD) direct_syms[key] = sym;
        else res.found = direct_syms[key];
      end
    end else if (req == REQ_ADD) begin
      if (entry_total >= ENTRY_CAP) begin
        res.status = 1'b1;
      end else begin
        entry_keys[entry_total] = key;
        entry_lens[entry_total] = len;
        entry_syms[entry_total] = sym;
        entry_total++;
      end
    end else begin
      for (int i = entry_total - 1; i >= 0; i--) begin
        if (entry_keys[i] == key && entry_lens[i] == len) begin
          res.found = entry_syms[i];
          break;
        end
      end
    end
    return res;
  endfunction

  task automatic queue_request(smhl_req_t req, logic [KEY_W-1:0] key, logic [LEN_W-1:0] len,
                               logic [OUT_SYM_W-1:0] sym);
    map_request_t item;
    item = '{req: req, key: key, len: len, sym: sym};
    pending_requests = {pending_requests, item};
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  // Sender. An accepted transaction is folded into the prediction at the same
  // edge, using the payload as it stood when the handshake completed. A new
  // item is offered only once the previous one has gone, so valid never drops
  // while an item is waiting for ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted = apply_map_request(smhl_req_t'(in_req_type), in_key_bytes,
                                      in_key_length, in_new_symbol);
        owed_results = {owed_results, predicted};
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          in_req_type   <= pending_requests[0].req;
          in_key_bytes  <= pending_requests[0].key;
          in_key_length <= pending_requests[0].len;
          in_new_symbol <= pending_requests[0].sym;
          in_valid      <= 1'b1;
          void'(pending_requests.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker. Each result transaction is matched against the
  // oldest owed result. Once the last third begins, ready is held low for a
  // long stretch so that the cell chain fills and the block pushes back on
  // its input while the sender keeps offering.
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  map_result_t owed;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("result with nothing owed: found_symbol %h status %0d",
                 out_found_symbol, out_status);
          mismatches++;
        end else begin
          owed = owed_results.pop_front();
          if (out_found_symbol !== owed.found) begin
            $error("found_symbol: expected %h, got %h", owed.found, out_found_symbol);
            mismatches++;
          end
          if (out_status !== owed.status) begin
            $error("status: expected %0d, got %0d", owed.status, out_status);
            mismatches++;
          end
        end
      end
      if (!hold_done && n_accepted * 3 >= total_items * 2) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
      end
    end
  end

  // Hang detector: ends the run when neither channel has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL symbol_map_hash_lookup");
    $finish;
  end

  initial begin : stimulus
    smhl_req_t        req;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
    known_key_t       pick;
    known_key_t       fresh;
    int               reuse_pct;

    foreach (direct_syms[i]) direct_syms[i] = '0;

    // Directed part. Lookups on an empty map, both ends of the direct table,
    // one-byte keys past the table, the full key width, junk above the key
    // length, equal bytes under different lengths, duplicate adds of both key
    // kinds, and requests with lengths outside one to four that must leave
    // the map untouched.
    queue_request(REQ_LOOKUP, 32'h0000_0000, LEN_BYTE, 16'hFFFF);
    queue_request(REQ_LOOKUP, 32'h0000_1234, 3'd2,     16'h0000);
    queue_request(REQ_ADD,    32'hFFFF_FF00, LEN_BYTE, 16'hFFFF);
    queue_request(REQ_LOOKUP, 32'h5A5A_5A00, LEN_BYTE, 16'h0000);
    queue_request(REQ_ADD,    32'h0000_007F, LEN_BYTE, 16'h1234);
    queue_request(REQ_LOOKUP, 32'hC3C3_C37F, LEN_BYTE, 16'h0000);
    queue_request(REQ_ADD,    32'h0000_0080, LEN_BYTE, 16'h5555);
    queue_request(REQ_LOOKUP, 32'h0000_0080, LEN_BYTE, 16'h0000);
    queue_request(REQ_ADD,    32'h0000_00FF, LEN_BYTE, 16'hAAAA);
    queue_request(REQ_LOOKUP, 32'hFFFF_FFFF, LEN_BYTE, 16'h0000);
    queue_request(REQ_ADD,    32'hFFFF_FFFF, LEN_MAX,  16'hA5A5);
    queue_request(REQ_LOOKUP, 32'hFFFF_FFFF, LEN_MAX,  16'h0000);
    queue_request(REQ_LOOKUP, 32'hFFFF_FFFF, 3'd3,     16'h0000);
    queue_request(REQ_ADD,    32'hDEAD_1234, 3'd2,     16'h1111);
    queue_request(REQ_ADD,    32'hBE00_1234, 3'd3,     16'h2222);
    queue_request(REQ_LOOKUP, 32'h0000_1234, 3'd2,     16'h0000);
    queue_request(REQ_LOOKUP, 32'h7700_1234, 3'd3,     16'h0000);
    queue_request(REQ_ADD,    32'h0000_1234, 3'd2,     16'h3333);
    queue_request(REQ_LOOKUP, 32'hFFFF_1234, 3'd2,     16'hFFFF);
    queue_request(REQ_ADD,    32'h0000_007F, LEN_BYTE, 16'h0001);
    queue_request(REQ_LOOKUP, 32'h0000_007F, LEN_BYTE, 16'h0000);
    queue_request(REQ_ADD,    32'h0000_0000, LEN_NONE, 16'h9999);
    queue_request(REQ_LOOKUP, 32'hFFFF_FFFF, LEN_OVER, 16'h0000);
    queue_request(REQ_ADD,    32'hFFFF_FFFF, LEN_TOP,  16'h7777);
    queue_request(REQ_LOOKUP, 32'h0000_0000, LEN_BYTE, 16'h0000);

    // Random part. Most lookups reuse a key that was added earlier, with fresh
    // junk above its length, so that hits, chain walks and newest-wins all get
    // exercised. Some adds repeat a known key. The multi-byte adds run the
    // entry store full partway through, after which they must be refused.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      req = ($urandom_range(99) < 45) ? REQ_ADD : REQ_LOOKUP;
      reuse_pct = (req == REQ_LOOKUP) ? 65 : 20;
      if ($urandom_range(99) < 4) begin
        len = $urandom_range(1) ? LEN_NONE : 3'($urandom_range(5, 7));
        key = $urandom();
      end else if (known_keys.size() != 0 && $urandom_range(99) < reuse_pct) begin
        pick = known_keys[$urandom_range(known_keys.size() - 1)];
        len  = pick.len;
        key  = pick.key | ($urandom() & ~key_mask(len));
      end else begin
        len = 3'($urandom_range(1, 4));
        key = $urandom();
        // Keep most one-byte keys inside the direct table.
        if (len == LEN_BYTE && $urandom_range(3) != 0) key[7] = 1'b0;
        if (req == REQ_ADD) begin
          fresh = '{key: key & key_mask(len), len: len};
          known_keys = {known_keys, fresh};
        end
      end
      queue_request(req, key, len, 16'($urandom()));
    end

    total_items = pending_requests.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted != total_items) @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    // Let a stray result surface if the block produces more than it owes.
    repeat (ENTRY_CAP + 16) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS symbol_map_hash_lookup");
    end else begin
      $display("FAIL symbol_map_hash_lookup");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
src/smhl_pkg.sv
src/smhl_ram.sv
src/smhl_cell.sv
src/symbol_map_hash_lookup.sv
src/smhl_checker.sv
verif/symbol_map_hash_lookup_tb.sv
